>>> hw/rtl/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared widths, request and status codes and controller states for the
// reversible queue with search.
// ----------------------------------------------------------------------------
package rqs_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_ENQUEUE = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_DEQUEUE = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_REVERSE = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_SEARCH  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_UPDATE  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_SCAN,
      ST_DONE
   } rqs_state_type;

endpackage

>>> hw/rtl/rqs_mem.sv
// ----------------------------------------------------------------------------
// rqs_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rqs_mem #(
   parameter int DEPTH = rqs_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [IDX_W-1:0]                    wr_addr,
   input  logic signed [rqs_pkg::VALUE_W-1:0]  wr_data,
   input  logic [IDX_W-1:0]                    rd_addr,
   output logic signed [rqs_pkg::VALUE_W-1:0]  rd_data
);

   logic signed [rqs_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [rqs_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/reversible_queue_with_search.sv
// ----------------------------------------------------------------------------
// reversible_queue_with_search
// Bounded FIFO of signed 32-bit words in a ring with head pointer, count and
// direction bit; enqueue, dequeue, reverse, search and update-first-match.
// ----------------------------------------------------------------------------
// One request word is taken at a time and yields exactly one response word.
// Enqueue, reverse and ignored request codes go from idle straight to the
// done state, as do dequeue, search and update on an empty queue. Dequeue
// passes through the dequeue state, where the front entry read from the
// entry store returns. Search and update pass through the scan state, which
// reads one entry per cycle from the single read port of the entry store
// and stops at the first match counted from the front or at the last live
// entry. In the done state the result waits until the output register is
// free. A new request is taken as soon as the controller is idle, even
// while the last response still waits in the output register. Entries are
// never cleared; only live ring slots are ever compared or returned.
// ----------------------------------------------------------------------------
module reversible_queue_with_search #(
   parameter int DEPTH = rqs_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rqs_pkg::TYPE_W-1:0]           req_type,
   input  logic signed [rqs_pkg::VALUE_W-1:0]   req_value,
   input  logic signed [rqs_pkg::VALUE_W-1:0]   req_new_value,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rqs_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [rqs_pkg::VALUE_W-1:0]   rsp_data_out,
   output logic                                 rsp_found,
   output logic [rqs_pkg::OCC_W-1:0]            rsp_occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W+1:0] DEPTH_EXT = (IDX_W + 2)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // Ring slot of logical position p counted from slot h, walking forward
   // or backward depending on the direction bit.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                                 input logic [IDX_W:0]   p,
                                                 input logic             rev);
      logic [IDX_W+1:0] s;
      if (rev) begin
         s = {2'b00, h} + DEPTH_EXT - {1'b0, p};
      end else begin
         s = {2'b00, h} + {1'b0, p};
      end
      if (s >= DEPTH_EXT) begin
         s = s - DEPTH_EXT;
      end
      return s[IDX_W-1:0];
   endfunction

   localparam logic [IDX_W:0] ONE_POS = (IDX_W + 1)'(1);

   // controller state
   rqs_pkg::rqs_state_type state_ff, state_in;

   // queue descriptor
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rev_ff, rev_in;

   // latched request
   logic [rqs_pkg::TYPE_W-1:0]         type_ff, type_in;
   logic signed [rqs_pkg::VALUE_W-1:0] value_ff, value_in;
   logic signed [rqs_pkg::VALUE_W-1:0] new_value_ff, new_value_in;

   // scan walker: slot and position whose data returns this cycle
   logic [IDX_W-1:0] scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0] scan_pos_ff, scan_pos_in;

   // pending result
   logic [rqs_pkg::STATUS_W-1:0]       res_status_ff, res_status_in;
   logic signed [rqs_pkg::VALUE_W-1:0] res_data_ff, res_data_in;
   logic                               res_found_ff, res_found_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rqs_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [rqs_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [rqs_pkg::OCC_W-1:0]          rsp_occ_ff, rsp_occ_in;

   // entry store ports
   logic                               mem_wr_en;
   logic [IDX_W-1:0]                   mem_wr_addr;
   logic signed [rqs_pkg::VALUE_W-1:0] mem_wr_data;
   logic [IDX_W-1:0]                   mem_rd_addr;
   logic signed [rqs_pkg::VALUE_W-1:0] mem_rd_data;

   logic req_accept;
   logic out_free;
   logic scan_match;
   logic scan_last;

   assign req_ready  = (state_ff == rqs_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign scan_match = (mem_rd_data == value_ff);
   assign scan_last  = (scan_pos_ff == count_ff - CNT_W'(1));

   rqs_mem #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rqs_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  rqs_pkg::REQ_DEQUEUE: begin
                     state_in = (count_ff == '0) ? rqs_pkg::ST_DONE : rqs_pkg::ST_DEQ;
                  end
                  rqs_pkg::REQ_SEARCH,
                  rqs_pkg::REQ_UPDATE: begin
                     state_in = (count_ff == '0) ? rqs_pkg::ST_DONE : rqs_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = rqs_pkg::ST_DONE;
                  end
               endcase
            end
         end
         rqs_pkg::ST_DEQ: begin
            state_in = rqs_pkg::ST_DONE;
         end
         rqs_pkg::ST_SCAN: begin
            if (scan_match || scan_last) begin
               state_in = rqs_pkg::ST_DONE;
            end
         end
         rqs_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = rqs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rqs_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      rev_in        = rev_ff;
      type_in       = type_ff;
      value_in      = value_ff;
      new_value_in  = new_value_ff;
      scan_slot_in  = scan_slot_ff;
      scan_pos_in   = scan_pos_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot_of(head_ff, (IDX_W + 1)'(count_ff), rev_ff);
      mem_wr_data   = req_value;
      // the walker reads ahead; in idle, point at the front
      mem_rd_addr   = (state_ff == rqs_pkg::ST_IDLE) ? head_ff
                                                     : slot_of(scan_slot_ff, ONE_POS, rev_ff);

      case (state_ff)
         rqs_pkg::ST_IDLE: begin
            if (req_accept) begin
               type_in       = req_type;
               value_in      = req_value;
               new_value_in  = req_new_value;
               res_status_in = rqs_pkg::STAT_OK;
               res_data_in   = '0;
               res_found_in  = 1'b0;
               scan_slot_in  = head_ff;
               scan_pos_in   = '0;
               case (req_type)
                  rqs_pkg::REQ_ENQUEUE: begin
                     if (count_ff == DEPTH_CNT) begin
                        res_status_in = rqs_pkg::STAT_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  rqs_pkg::REQ_DEQUEUE: begin
                     // front read is in flight; advance head now
                     if (count_ff == '0) begin
                        res_status_in = rqs_pkg::STAT_EMPTY;
                     end else begin
                        head_in  = slot_of(head_ff, ONE_POS, rev_ff);
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  rqs_pkg::REQ_REVERSE: begin
                     // rear becomes front, flip direction
                     if (count_ff == '0) begin
                        res_status_in = rqs_pkg::STAT_EMPTY;
                     end else begin
                        head_in = slot_of(head_ff, (IDX_W + 1)'(count_ff - CNT_W'(1)), rev_ff);
                        rev_in  = !rev_ff;
                     end
                  end
                  rqs_pkg::REQ_SEARCH,
                  rqs_pkg::REQ_UPDATE: begin
                     if (count_ff == '0) begin
                        res_status_in = rqs_pkg::STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         rqs_pkg::ST_DEQ: begin
            res_data_in = mem_rd_data;
         end
         rqs_pkg::ST_SCAN: begin
            if (scan_match) begin
               res_found_in = 1'b1;
               if (type_ff == rqs_pkg::REQ_UPDATE) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = scan_slot_ff;
                  mem_wr_data = new_value_ff;
               end
            end else if (scan_last) begin
               res_status_in = rqs_pkg::STAT_NOT_FOUND;
            end else begin
               // advance to the next slot
               scan_slot_in = slot_of(scan_slot_ff, ONE_POS, rev_ff);
               scan_pos_in  = scan_pos_ff + CNT_W'(1);
            end
         end
         rqs_pkg::ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               rsp_found_in  = res_found_ff;
               rsp_occ_in    = rqs_pkg::OCC_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqs_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      value_ff      <= value_in;
      new_value_ff  <= new_value_in;
      scan_slot_ff  <= scan_slot_in;
      scan_pos_ff   <= scan_pos_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

>>> hw/rtl/rqs_checker.sv
// ----------------------------------------------------------------------------
// rqs_checker
// Port-level checks on the response channel of the reversible queue.
// ----------------------------------------------------------------------------
module rqs_checker #(
   parameter int DEPTH = rqs_pkg::DEPTH_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [rqs_pkg::STATUS_W-1:0]         rsp_status,
   input logic signed [rqs_pkg::VALUE_W-1:0]   rsp_data_out,
   input logic                                 rsp_found,
   input logic [rqs_pkg::OCC_W-1:0]            rsp_occupancy
);

   localparam logic [rqs_pkg::OCC_W-1:0] FULL_OCC = rqs_pkg::OCC_W'(DEPTH);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_out) && $stable(rsp_found) && $stable(rsp_occupancy))
      else $error("response word changed while stalled");

   // no response directly after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // full status only at full occupancy
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rqs_pkg::STAT_FULL |-> rsp_occupancy == FULL_OCC)
      else $error("full status with occupancy below depth");

   // a match always reports ok and zero data
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == rqs_pkg::STAT_OK
         && rsp_data_out == '0)
      else $error("found word carries bad status or data");

   // only a good dequeue carries data
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_out != '0 |-> rsp_status == rqs_pkg::STAT_OK && !rsp_found)
      else $error("data on a word that is not a good dequeue");

endmodule

bind reversible_queue_with_search rqs_checker #(.DEPTH(DEPTH)) u_rqs_checker (.*);

>>> tb/tb_reversible_queue_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reversible_queue_with_search
// Self-checking bench for the reversible queue with search: a queued driver
// feeds request words, a shadow ring predicts each response word, and a
// monitor compares every response against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_reversible_queue_with_search;

   localparam int DEPTH        = rqs_pkg::DEPTH_DEFAULT;
   localparam int TYPE_W       = rqs_pkg::TYPE_W;
   localparam int VALUE_W      = rqs_pkg::VALUE_W;
   localparam int STATUS_W     = rqs_pkg::STATUS_W;
   localparam int OCC_W        = rqs_pkg::OCC_W;
   localparam int RESET_CYCLES = 9;
   localparam int TIMEOUT_NS   = 5_000_000;

   // request codes the block ignores
   localparam logic [TYPE_W-1:0] REQ_IGNORED_FIRST = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_IGNORED_MID   = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_IGNORED_LAST  = 3'd7;

   // traffic phases: slow receiver, slow sender, full speed
   localparam int PH_SLOW_RECV = 0;
   localparam int PH_SLOW_SEND = 1;
   localparam int PH_FULL_RATE = 2;
   localparam int SEND_IDLE_PCT [3] = '{36, 50, 0};
   localparam int RECV_IDLE_PCT [3] = '{50, 36, 0};

   // request mixes of the random part
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   typedef struct {
      logic [TYPE_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] new_value;
      bit                        drain;    // hold until all responses are back
      int                        phase;
   } req_word_type;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] data_out;
      logic                      found;
      logic [OCC_W-1:0]          occupancy;
   } rsp_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [TYPE_W-1:0]         req_type = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic signed [VALUE_W-1:0] req_new_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_data_out;
   logic                      rsp_found;
   logic [OCC_W-1:0]          rsp_occupancy;

   req_word_type pending_words[$];
   rsp_word_type expected_results[$];
   req_word_type driven_word;
   rsp_word_type predicted;
   rsp_word_type oldest;
   logic         req_taken = 1'b0;
   int           cur_phase = PH_SLOW_RECV;
   int           words_total = 0;
   int           words_accepted = 0;
   int           error_count = 0;

   // shadow of the ring
   logic signed [VALUE_W-1:0] ring_entries [DEPTH];
   int                        ring_head = 0;
   int                        ring_count = 0;
   bit                        ring_reversed = 1'b0;

   reversible_queue_with_search #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_value     (req_value),
      .req_new_value (req_new_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data_out  (rsp_data_out),
      .rsp_found     (rsp_found),
      .rsp_occupancy (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow ring
   // ------------------------------------------------------------------

   // Map a logical position (0 = front) to its ring slot.
   function automatic int ring_slot(int pos);
      if (ring_reversed) begin
         return (ring_head + DEPTH - (pos % DEPTH)) % DEPTH;
      end
      return (ring_head + pos) % DEPTH;
   endfunction

   // Scan from the front over live entries only; -1 when nothing matches.
   function automatic int first_match_slot(logic signed [VALUE_W-1:0] v);
      for (int i = 0; i < ring_count; i++) begin
         if (ring_entries[ring_slot(i)] == v) begin
            return ring_slot(i);
         end
      end
      return -1;
   endfunction

   // Apply one request word to the shadow ring and build its response word.
   task automatic predict_queue_op(input req_word_type w, output rsp_word_type r);
      int s;
      r.status   = rqs_pkg::STAT_OK;
      r.data_out = '0;
      r.found    = 1'b0;
      case (w.kind)
         rqs_pkg::REQ_ENQUEUE: begin
            if (ring_count >= DEPTH) begin
               r.status = rqs_pkg::STAT_FULL;
            end else begin
               ring_entries[ring_slot(ring_count)] = w.value;
               ring_count++;
            end
         end
         rqs_pkg::REQ_DEQUEUE: begin
            if (ring_count == 0) begin
               r.status = rqs_pkg::STAT_EMPTY;
            end else begin
               r.data_out = ring_entries[ring_slot(0)];
               ring_head  = ring_slot(1);
               ring_count--;
            end
         end
         rqs_pkg::REQ_REVERSE: begin
            if (ring_count == 0) begin
               r.status = rqs_pkg::STAT_EMPTY;
            end else begin
               // the rear becomes the front, then walk the other way
               ring_head     = ring_slot(ring_count - 1);
               ring_reversed = !ring_reversed;
            end
         end
         rqs_pkg::REQ_SEARCH, rqs_pkg::REQ_UPDATE: begin
            s = first_match_slot(w.value);
            if (s < 0) begin
               r.status = rqs_pkg::STAT_NOT_FOUND;
            end else begin
               r.found = 1'b1;
               if (w.kind == rqs_pkg::REQ_UPDATE) begin
                  ring_entries[s] = w.new_value;
               end
            end
         end
         default: begin
         end
      endcase
      r.occupancy = OCC_W'(ring_count);
   endtask

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------

   task automatic push_word(logic [TYPE_W-1:0] kind, logic signed [VALUE_W-1:0] value,
                            logic signed [VALUE_W-1:0] new_value, bit drain);
      req_word_type w;
      w.kind      = kind;
      w.value     = value;
      w.new_value = new_value;
      w.drain     = drain;
      w.phase     = PH_SLOW_RECV;
      pending_words.push_back(w);
   endtask

   // Mostly a small pool so searches and updates hit; the rest full range.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(99) >= 70) begin
         return $urandom;
      end
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sh0000_0000;
         3: return -32'sd1;
         4: return 32'sh0000_0001;
         5: return 32'sh5a5a_5a5a;
         6: return 32'sh1234_5678;
         default: return -32'sd2;
      endcase
   endfunction

   function automatic logic [TYPE_W-1:0] pick_kind(int mode);
      int enq_cut;
      int deq_cut;
      int roll;
      enq_cut = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 10 : 30;
      deq_cut = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 60 : 55;
      roll = $urandom_range(99);
      if (roll < enq_cut) begin
         return rqs_pkg::REQ_ENQUEUE;
      end
      if (roll < deq_cut) begin
         return rqs_pkg::REQ_DEQUEUE;
      end
      roll = $urandom_range(99);
      if (roll < 25) begin
         return rqs_pkg::REQ_REVERSE;
      end
      if (roll < 55) begin
         return rqs_pkg::REQ_SEARCH;
      end
      if (roll < 90) begin
         return rqs_pkg::REQ_UPDATE;
      end
      return TYPE_W'($urandom_range(REQ_IGNORED_LAST, REQ_IGNORED_FIRST));
   endfunction

   // Queue random words in runs of fill, drain or mixed traffic; ignored
   // request codes ride along but are not counted.
   task automatic add_random_words(int phase, int count);
      req_word_type w;
      int           issued;
      int           run_left;
      int           mode;
      issued   = 0;
      run_left = 0;
      mode     = MODE_MIX;
      while (issued < count) begin
         if (run_left == 0) begin
            mode     = $urandom_range(MODE_MIX, MODE_FILL);
            run_left = $urandom_range(24, 6);
         end
         run_left--;
         w.kind      = pick_kind(mode);
         w.value     = pick_value();
         w.new_value = pick_value();
         w.drain     = (issued == 0) || ($urandom_range(99) == 0);
         w.phase     = phase;
         pending_words.push_back(w);
         if (w.kind <= rqs_pkg::REQ_UPDATE) begin
            issued++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: present the next word at the falling edge once the previous
   // one has been taken
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_words[0].drain && expected_results.size() != 0) begin
            // hold off until every outstanding response is back
            req_valid <= 1'b0;
         end else if ($urandom_range(99) < SEND_IDLE_PCT[pending_words[0].phase]) begin
            req_valid <= 1'b0;
         end else begin
            driven_word = pending_words.pop_front();
            req_valid     <= 1'b1;
            req_type      <= driven_word.kind;
            req_value     <= driven_word.value;
            req_new_value <= driven_word.new_value;
         end
      end
   end

   // Receiver back-pressure, by phase.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= RECV_IDLE_PCT[cur_phase]);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check responses first, then predict for the accepted request
   // ------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response word with no request outstanding");
               error_count++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("status", 32'(oldest.status), 32'(rsp_status));
               check_field("data_out", 32'(oldest.data_out), 32'(rsp_data_out));
               check_field("found", 32'(oldest.found), 32'(rsp_found));
               check_field("occupancy", 32'(oldest.occupancy), 32'(rsp_occupancy));
            end
         end
         if (req_valid && req_ready) begin
            predict_queue_op(driven_word, predicted);
            expected_results.push_back(predicted);
            words_accepted++;
            cur_phase <= driven_word.phase;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      // empty queue: every failing case
      push_word(rqs_pkg::REQ_SEARCH,  32'sd0, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_UPDATE,  32'sd0, 32'sd9, 1'b0);
      push_word(rqs_pkg::REQ_DEQUEUE, 32'sd0, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_REVERSE, 32'sd0, 32'sd0, 1'b0);
      // single entry, then reverse it in place
      push_word(rqs_pkg::REQ_ENQUEUE, 32'sh8000_0000, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_REVERSE, 32'sd0, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_SEARCH,  32'sh8000_0000, 32'sd0, 1'b0);
      // field extremes
      push_word(rqs_pkg::REQ_ENQUEUE, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
      push_word(rqs_pkg::REQ_ENQUEUE, 32'sd0, 32'sh7fff_ffff, 1'b0);
      push_word(rqs_pkg::REQ_ENQUEUE, -32'sd1, -32'sd1, 1'b0);
      push_word(rqs_pkg::REQ_SEARCH,  32'sh7fff_ffff, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_SEARCH,  32'sd12345, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_UPDATE,  -32'sd1, 32'sh5555_5555, 1'b0);
      push_word(rqs_pkg::REQ_UPDATE,  32'sd777, 32'sd1, 1'b0);
      push_word(rqs_pkg::REQ_REVERSE, 32'sd0, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_DEQUEUE, 32'sd0, 32'sd0, 1'b1);
      // ignored codes
      push_word(REQ_IGNORED_FIRST, 32'sh7fff_ffff, -32'sd1, 1'b0);
      push_word(REQ_IGNORED_MID, -32'sd1, 32'sh8000_0000, 1'b0);
      push_word(REQ_IGNORED_LAST, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      // drain back to empty
      push_word(rqs_pkg::REQ_SEARCH,  32'sh5555_5555, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_DEQUEUE, 32'sd0, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_DEQUEUE, 32'sd0, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_DEQUEUE, 32'sd0, 32'sd0, 1'b0);
      push_word(rqs_pkg::REQ_DEQUEUE, 32'sd0, 32'sd0, 1'b0);

      add_random_words(PH_SLOW_RECV, 333);
      add_random_words(PH_SLOW_SEND, 333);
      add_random_words(PH_FULL_RATE, 334);
      words_total = pending_words.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // both counters and the queue only move at the rising edge
      while (words_accepted != words_total || expected_results.size() != 0) begin
         @(negedge clock);
      end
      // let the longest scan settle to catch stray responses
      repeat (DEPTH + 4) @(negedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d response words never arrived", expected_results.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("tb_reversible_queue_with_search: clean");
      end else begin
         $display("tb_reversible_queue_with_search: errors");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_reversible_queue_with_search: errors");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/rqs_pkg.sv
hw/rtl/rqs_mem.sv
hw/rtl/reversible_queue_with_search.sv
hw/rtl/rqs_checker.sv
tb/tb_reversible_queue_with_search.sv
